// ===== hdl/dpct_pkg.sv =====
// ---------------------------------------------------------------------------
// dpct_pkg : shared definitions for the 2x2 dual-polarisation correlator tile
// Lane count, field widths, default precisions and the lane control bundle.
// ---------------------------------------------------------------------------
package dpct_pkg;

	// default precisions handed to the top level parameters
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ACC_BITS_DEF    = 48;

	// fixed field geometry
	localparam int STATION_BITS  = 64;
	localparam int LANE_BITS     = 16;
	localparam int OUT_BITS      = 48;
	localparam int NUM_STATIONS  = 4;
	localparam int NUM_LANES     = 16;
	localparam int LANE_IDX_BITS = $clog2(NUM_LANES);

	// lane index of the final visibility of a tile
	localparam logic [LANE_IDX_BITS-1:0] LAST_LANE = LANE_IDX_BITS'(NUM_LANES - 1);

	// pipeline control shared by every lane
	typedef struct packed {
		logic adv;     // all stages move one step
		logic acc_en;  // a valid sample sits in the sum stage
		logic clear;   // that sample closes the tile
	} lane_ctrl_t;

endpackage

// ===== hdl/dpct_lane.sv =====
// ---------------------------------------------------------------------------
// dpct_lane : one complex multiply-accumulate lane
// Accumulates p times conj(q) for one baseline and polarisation product.
// ---------------------------------------------------------------------------
module dpct_lane #(
	parameter int SAMPLE_BITS = dpct_pkg::SAMPLE_BITS_DEF,
	parameter int ACC_BITS    = dpct_pkg::ACC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dpct_pkg::lane_ctrl_t          ctrl,
	input  logic signed [SAMPLE_BITS-1:0] p_re,
	input  logic signed [SAMPLE_BITS-1:0] p_im,
	input  logic signed [SAMPLE_BITS-1:0] q_re,
	input  logic signed [SAMPLE_BITS-1:0] q_im,
	output logic signed [ACC_BITS-1:0]    snap_re,
	output logic signed [ACC_BITS-1:0]    snap_im
);

	localparam int PROD_BITS = 2 * SAMPLE_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int WIDE_BITS = (ACC_BITS > SUM_BITS) ? ACC_BITS : SUM_BITS;

	logic signed [PROD_BITS-1:0] rr_s1, ii_s1, ir_s1, ri_s1;
	logic signed [WIDE_BITS-1:0] sum_re_w, sum_im_w;
	logic signed [ACC_BITS-1:0]  sum_re_s2, sum_im_s2;
	logic signed [ACC_BITS-1:0]  acc_re_q, acc_im_q;

	// partial products
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			rr_s1 <= p_re * q_re;
			ii_s1 <= p_im * q_im;
			ir_s1 <= p_im * q_re;
			ri_s1 <= p_re * q_im;
		end
	end

	// real and imaginary sums, wrapped to accumulator width
	assign sum_re_w = WIDE_BITS'(rr_s1) + WIDE_BITS'(ii_s1);
	assign sum_im_w = WIDE_BITS'(ir_s1) - WIDE_BITS'(ri_s1);

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			sum_re_s2 <= sum_re_w[ACC_BITS-1:0];
			sum_im_s2 <= sum_im_w[ACC_BITS-1:0];
		end
	end

	// running total including the sample now in the sum stage
	assign snap_re = acc_re_q + sum_re_s2;
	assign snap_im = acc_im_q + sum_im_s2;

	// accumulator, restarts from zero after the tile's final sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (ctrl.adv && ctrl.acc_en) begin
			acc_re_q <= ctrl.clear ? '0 : snap_re;
			acc_im_q <= ctrl.clear ? '0 : snap_im;
		end
	end

endmodule

// ===== hdl/dpct_merge.sv =====
// ---------------------------------------------------------------------------
// dpct_merge : visibility gather and output sequencer
// Captures all lane totals at a tile end, sends one word a cycle if out_ready.
// ---------------------------------------------------------------------------
module dpct_merge #(
	parameter int ACC_BITS = dpct_pkg::ACC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   capture,
	input  logic signed [ACC_BITS-1:0]             snap_re [dpct_pkg::NUM_LANES],
	input  logic signed [ACC_BITS-1:0]             snap_im [dpct_pkg::NUM_LANES],
	output logic                                   busy,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             pair_index,
	output logic [1:0]                             pol_product,
	output logic signed [dpct_pkg::OUT_BITS-1:0]   vis_real,
	output logic signed [dpct_pkg::OUT_BITS-1:0]   vis_imag,
	output logic                                   last_result
);

	localparam int OB = dpct_pkg::OUT_BITS;

	logic signed [ACC_BITS-1:0]            vis_re_q [dpct_pkg::NUM_LANES];
	logic signed [ACC_BITS-1:0]            vis_im_q [dpct_pkg::NUM_LANES];
	logic [dpct_pkg::LANE_IDX_BITS-1:0]    cnt_q;
	logic                                  busy_q;
	logic                                  out_fire;
	logic                                  is_last;

	// snapshot of the tile's visibilities
	always_ff @(posedge clk) begin
		if (capture) begin
			for (int i = 0; i < dpct_pkg::NUM_LANES; i++) begin
				vis_re_q[i] <= snap_re[i];
				vis_im_q[i] <= snap_im[i];
			end
		end
	end

	assign out_fire = busy_q && out_ready;
	assign is_last  = (cnt_q == dpct_pkg::LAST_LANE);

	// drain counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (capture) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (out_fire) begin
			cnt_q <= cnt_q + 1'b1;
			if (is_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// output word
	assign busy        = busy_q;
	assign out_valid   = busy_q;
	assign pair_index  = cnt_q[3:2];
	assign pol_product = cnt_q[1:0];
	assign vis_real    = OB'(vis_re_q[cnt_q]);
	assign vis_imag    = OB'(vis_im_q[cnt_q]);
	assign last_result = is_last;

`ifndef SYNTHESIS
	// a fresh snapshot never lands on words still being sent
	a_capture_idle : assert property (@(posedge clk) disable iff (!arst_n)
		capture |-> !busy_q)
		else $error("snapshot taken while previous tile still draining");

	// the final word ends the burst
	a_burst_end : assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && is_last) |=> !out_valid)
		else $error("output still valid after final visibility");

	// counter rests at zero between bursts
	a_cnt_idle : assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (cnt_q == '0))
		else $error("drain counter not at zero while idle");
`endif

endmodule

// ===== hdl/dual_pol_correlator_tile_2x2_unit.sv =====
// ---------------------------------------------------------------------------
// dual_pol_correlator_tile_2x2_unit : 2x2 dual-polarisation correlator tile
// Sixteen complex MAC lanes accumulate a or b times conj(c or d) per sample;
// at a tile end the merge stage emits the sixteen visibilities in lane order.
// ---------------------------------------------------------------------------
//  channel  | handshake           | word
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_ready | station_a..d_sample, last_time
//  output   | out_valid/out_ready | pair_index, pol_product, vis_real,
//           |                     | vis_imag, last_result
//
//  one sample word accepted per cycle while in_ready is high; products, sums
//  and the snapshot are registered in turn between the word with last_time
//  and the first visibility of its tile; the sixteen visibilities leave one
//  per cycle while out_ready is high; a tile end that meets an undrained burst
//  holds in_ready low (with out_ready high: tiles under 17)
//  reset clears the accumulators, the pipeline valids and the drain counter
// ---------------------------------------------------------------------------
module dual_pol_correlator_tile_2x2_unit #(
	parameter int SAMPLE_BITS = dpct_pkg::SAMPLE_BITS_DEF,
	parameter int ACC_BITS    = dpct_pkg::ACC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [dpct_pkg::STATION_BITS-1:0]     station_a_sample,
	input  logic [dpct_pkg::STATION_BITS-1:0]     station_b_sample,
	input  logic [dpct_pkg::STATION_BITS-1:0]     station_c_sample,
	input  logic [dpct_pkg::STATION_BITS-1:0]     station_d_sample,
	input  logic                                  last_time,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            pair_index,
	output logic [1:0]                            pol_product,
	output logic signed [dpct_pkg::OUT_BITS-1:0]  vis_real,
	output logic signed [dpct_pkg::OUT_BITS-1:0]  vis_imag,
	output logic                                  last_result
);

	localparam int SB = dpct_pkg::STATION_BITS;
	localparam int LB = dpct_pkg::LANE_BITS;

	logic [SB-1:0]              station [dpct_pkg::NUM_STATIONS];
	logic signed [ACC_BITS-1:0] snap_re [dpct_pkg::NUM_LANES];
	logic signed [ACC_BITS-1:0] snap_im [dpct_pkg::NUM_LANES];
	dpct_pkg::lane_ctrl_t       ctrl;
	logic                       v_s1, v_s2, last_s1, last_s2;
	logic                       busy;
	logic                       adv;
	logic                       capture;

	assign station[0] = station_a_sample;
	assign station[1] = station_b_sample;
	assign station[2] = station_c_sample;
	assign station[3] = station_d_sample;

	// pipeline only holds when a tile end meets an undrained burst
	assign adv      = !(v_s2 && last_s2 && busy);
	assign in_ready = adv;
	assign capture  = adv && v_s2 && last_s2;

	// pipeline valid and tile-end flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_valid;
			last_s1 <= in_valid && last_time;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	assign ctrl.adv    = adv;
	assign ctrl.acc_en = v_s2;
	assign ctrl.clear  = last_s2;

	// sixteen lanes: pair (left a/b, right c/d) by polarisation product
	for (genvar l = 0; l < dpct_pkg::NUM_LANES; l++) begin : g_lane
		localparam int PR   = l / 4;
		localparam int PP   = l % 4;
		localparam int LST  = PR % 2;
		localparam int RST  = 2 + PR / 2;
		localparam int LPOL = PP / 2;
		localparam int RPOL = PP % 2;
		localparam int LRE  = SB - LB * (2 * LPOL + 1);
		localparam int LIM  = SB - LB * (2 * LPOL + 2);
		localparam int RRE  = SB - LB * (2 * RPOL + 1);
		localparam int RIM  = SB - LB * (2 * RPOL + 2);

		dpct_lane #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.ACC_BITS    (ACC_BITS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.p_re    (signed'(station[LST][LRE +: SAMPLE_BITS])),
			.p_im    (signed'(station[LST][LIM +: SAMPLE_BITS])),
			.q_re    (signed'(station[RST][RRE +: SAMPLE_BITS])),
			.q_im    (signed'(station[RST][RIM +: SAMPLE_BITS])),
			.snap_re (snap_re[l]),
			.snap_im (snap_im[l])
		);
	end

	// gather and send visibilities
	dpct_merge #(
		.ACC_BITS (ACC_BITS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.capture     (capture),
		.snap_re     (snap_re),
		.snap_im     (snap_im),
		.busy        (busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pair_index  (pair_index),
		.pol_product (pol_product),
		.vis_real    (vis_real),
		.vis_imag    (vis_imag),
		.last_result (last_result)
	);

`ifndef SYNTHESIS
	// a held tile end stays in place until the burst has drained
	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (v_s2 && last_s2))
		else $error("tile end lost during stall");

	// a tile end only flags a sample that was valid
	a_last_valid : assert property (@(posedge clk) disable iff (!arst_n)
		last_s2 |-> v_s2)
		else $error("tile end flagged without a sample");

	// a waiting output word keeps its valid and payload
	a_out_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pair_index) &&
		$stable(pol_product) && $stable(vis_real) && $stable(vis_imag)))
		else $error("output word changed while waiting");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb : self-checking bench for dual_pol_correlator_tile_2x2_unit
// Sample words go in through a queue-fed driver. An own model of the sixteen
// complex accumulators predicts every visibility, and a monitor checks each
// output word against the oldest prediction. Both sides idle at random.
// Directed tiles cover lane extremes and the pol/baseline mapping.
// Random tiles of mixed length follow.
// ---------------------------------------------------------------------------
module tb;

	localparam int S_W      = dpct_pkg::SAMPLE_BITS_DEF;
	localparam int ACC_W    = dpct_pkg::ACC_BITS_DEF;
	localparam int OUT_W    = dpct_pkg::OUT_BITS;
	localparam int ST_W     = dpct_pkg::STATION_BITS;
	localparam int N_VIS    = dpct_pkg::NUM_LANES;

	// one sample word plus its pacing
	typedef struct packed {
		logic [3:0][ST_W-1:0] st;
		logic                 last;
		logic                 hold;
		logic [3:0]           gap_max;
	} sample_word_t;

	// one visibility as the block should emit it
	typedef struct packed {
		logic [1:0]              pair;
		logic [1:0]              pol;
		logic signed [OUT_W-1:0] re;
		logic signed [OUT_W-1:0] im;
		logic                    last;
	} vis_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                          in_valid         = 1'b0;
	logic                          in_ready;
	logic [ST_W-1:0]               station_a_sample = '0;
	logic [ST_W-1:0]               station_b_sample = '0;
	logic [ST_W-1:0]               station_c_sample = '0;
	logic [ST_W-1:0]               station_d_sample = '0;
	logic                          last_time        = 1'b0;
	logic                          out_valid;
	logic                          out_ready        = 1'b0;
	logic [1:0]                    pair_index;
	logic [1:0]                    pol_product;
	logic signed [OUT_W-1:0]       vis_real;
	logic signed [OUT_W-1:0]       vis_imag;
	logic                          last_result;

	sample_word_t word_q[$];
	vis_word_t    vis_expected[$];
	sample_word_t cur_word;

	// predicted accumulator contents, low ACC_W bits used
	longint acc_re[N_VIS];
	longint acc_im[N_VIS];

	int tx_gap       = 0;
	int rx_hold      = 0;
	int rx_stall_max = 15;
	int err_cnt      = 0;
	int words_sent   = 0;
	int tiles_queued = 0;
	int vis_checked  = 0;

	dual_pol_correlator_tile_2x2_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.station_a_sample (station_a_sample),
		.station_b_sample (station_b_sample),
		.station_c_sample (station_c_sample),
		.station_d_sample (station_d_sample),
		.last_time        (last_time),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.pair_index       (pair_index),
		.pol_product      (pol_product),
		.vis_real         (vis_real),
		.vis_imag         (vis_imag),
		.last_result      (last_result)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// signed value of one 16-bit lane, only the low S_W bits count
	function automatic longint lane_val(logic [ST_W-1:0] w, int lane);
		logic [15:0] raw;
		longint      v;
		raw = w[ST_W-1-16*lane -: 16];
		v = longint'(raw[S_W-1:0]);
		if (raw[S_W-1])
			v = v - (longint'(1) << S_W);
		return v;
	endfunction

	// accumulator bits sign-extended to the output width
	function automatic logic [OUT_W-1:0] acc_to_out(longint a);
		logic [63:0] t;
		t = a;
		if (t[ACC_W-1])
			t = t | ~((64'd1 << ACC_W) - 64'd1);
		return t[OUT_W-1:0];
	endfunction

	// add p*conj(q) for every baseline and pol pair; emit and clear on last
	function automatic void correlate_sample(sample_word_t s);
		longint    mask;
		longint    pr_, pi_, qr, qi;
		int        lft, rgt, k;
		vis_word_t v;
		mask = (longint'(1) << ACC_W) - 1;
		for (int pr = 0; pr < 4; pr++) begin
			lft = pr & 1;
			rgt = 2 + (pr >> 1);
			for (int pp = 0; pp < 4; pp++) begin
				k   = pr * 4 + pp;
				pr_ = lane_val(s.st[lft], 2 * (pp >> 1));
				pi_ = lane_val(s.st[lft], 2 * (pp >> 1) + 1);
				qr  = lane_val(s.st[rgt], 2 * (pp & 1));
				qi  = lane_val(s.st[rgt], 2 * (pp & 1) + 1);
				acc_re[k] = (acc_re[k] + pr_ * qr + pi_ * qi) & mask;
				acc_im[k] = (acc_im[k] + pi_ * qr - pr_ * qi) & mask;
			end
		end
		if (s.last) begin
			for (k = 0; k < N_VIS; k++) begin
				v.pair = 2'(k >> 2);
				v.pol  = 2'(k & 3);
				v.re   = acc_to_out(acc_re[k]);
				v.im   = acc_to_out(acc_im[k]);
				v.last = (k == N_VIS - 1);
				vis_expected.push_back(v);
				acc_re[k] = 0;
				acc_im[k] = 0;
			end
		end
	endfunction

	// input driver: one word in flight, random gap after each word
	always @(posedge clk or negedge arst_n) begin : drive_words
		sample_word_t nxt;
		logic         nv;
		if (!arst_n) begin
			in_valid         <= 1'b0;
			station_a_sample <= '0;
			station_b_sample <= '0;
			station_c_sample <= '0;
			station_d_sample <= '0;
			last_time        <= 1'b0;
			tx_gap = 0;
		end else begin
			nv = in_valid;
			if (in_valid && in_ready) begin
				correlate_sample(cur_word);
				words_sent++;
				nv = 1'b0;
			end
			if (!nv) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (word_q.size() != 0 &&
				             !(word_q[0].hold && vis_expected.size() != 0)) begin
					nxt = word_q.pop_front();
					cur_word = nxt;
					station_a_sample <= nxt.st[0];
					station_b_sample <= nxt.st[1];
					station_c_sample <= nxt.st[2];
					station_d_sample <= nxt.st[3];
					last_time        <= nxt.last;
					tx_gap = $urandom_range(0, nxt.gap_max);
					nv = 1'b1;
				end
			end
			in_valid <= nv;
		end
	end

	// output monitor: check each visibility word, stall at random
	always @(posedge clk or negedge arst_n) begin : check_vis
		vis_word_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_hold = 0;
		end else begin
			if (out_valid && out_ready) begin
				vis_checked++;
				if (vis_expected.size() == 0) begin
					$error("unexpected visibility: pair_index %0d pol_product %0d",
					       pair_index, pol_product);
					err_cnt++;
				end else begin
					e = vis_expected.pop_front();
					if (pair_index !== e.pair) begin
						$error("pair_index: expected %0d, got %0d", e.pair, pair_index);
						err_cnt++;
					end
					if (pol_product !== e.pol) begin
						$error("pol_product: expected %0d, got %0d", e.pol, pol_product);
						err_cnt++;
					end
					if (vis_real !== e.re) begin
						$error("vis_real: expected %0d, got %0d", e.re, vis_real);
						err_cnt++;
					end
					if (vis_imag !== e.im) begin
						$error("vis_imag: expected %0d, got %0d", e.im, vis_imag);
						err_cnt++;
					end
					if (last_result !== e.last) begin
						$error("last_result: expected %0d, got %0d", e.last, last_result);
						err_cnt++;
					end
				end
				rx_hold = $urandom_range(0, rx_stall_max);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [ST_W-1:0] pack_lanes(logic [15:0] xr, logic [15:0] xi,
	                                               logic [15:0] yr, logic [15:0] yi);
		return {xr, xi, yr, yi};
	endfunction

	// lanes lean towards the extremes
	function automatic logic [ST_W-1:0] rand_station();
		logic [15:0] l[4];
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 7))
				0:       l[i] = 16'h8000;
				1:       l[i] = 16'h7fff;
				2:       l[i] = 16'h0000;
				3:       l[i] = 16'hffff;
				default: l[i] = 16'($urandom);
			endcase
		end
		return pack_lanes(l[0], l[1], l[2], l[3]);
	endfunction

	task automatic queue_word(logic [ST_W-1:0] a, logic [ST_W-1:0] b,
	                          logic [ST_W-1:0] c, logic [ST_W-1:0] d,
	                          logic last, logic hold, logic [3:0] gap_max);
		sample_word_t w;
		w.st      = {d, c, b, a};
		w.last    = last;
		w.hold    = hold;
		w.gap_max = gap_max;
		word_q.push_back(w);
		if (last)
			tiles_queued++;
	endtask

	task automatic wait_idle();
		while (word_q.size() != 0 || in_valid || vis_expected.size() != 0)
			@(negedge clk);
	endtask

	// stimulus and end of run
	initial begin : stimulus
		logic [ST_W-1:0] s_pos, s_neg, s_alt, s_alt_n;
		logic [3:0]      gmax;
		int              n, len;
		for (int k = 0; k < N_VIS; k++) begin
			acc_re[k] = 0;
			acc_im[k] = 0;
		end
		s_pos   = pack_lanes(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		s_neg   = pack_lanes(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		s_alt   = pack_lanes(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		s_alt_n = pack_lanes(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed single-word tiles: zero, extremes, minus one, mapping check
		queue_word('0, '0, '0, '0, 1'b1, 1'b0, 4'd15);
		queue_word(s_pos, s_pos, s_pos, s_pos, 1'b1, 1'b0, 4'd15);
		queue_word(s_neg, s_neg, s_neg, s_neg, 1'b1, 1'b0, 4'd15);
		queue_word(s_alt, s_alt, s_alt_n, s_alt_n, 1'b1, 1'b0, 4'd15);
		queue_word('1, '1, '1, '1, 1'b1, 1'b0, 4'd15);
		queue_word(pack_lanes(16'd1, 16'd2, 16'd3, 16'd4),
		           pack_lanes(-16'sd5, 16'd6, -16'sd7, 16'd8),
		           pack_lanes(16'd9, -16'sd10, 16'd11, -16'sd12),
		           pack_lanes(-16'sd13, 16'd14, 16'd15, -16'sd16), 1'b1, 1'b0, 4'd15);
		// sender holds off until the earlier bursts are out
		for (int i = 0; i < 4; i++)
			queue_word(rand_station(), rand_station(), rand_station(), rand_station(),
			           i == 3, i == 0, 4'd15);
		// two-word tile: max positive then max negative
		queue_word(s_pos, s_pos, s_pos, s_pos, 1'b0, 1'b0, 4'd15);
		queue_word(s_neg, s_neg, s_neg, s_neg, 1'b1, 1'b0, 4'd15);
		wait_idle();

		// random tiles, mostly short, output pacing varied per block
		for (int blk = 0; blk < 4; blk++) begin
			rx_stall_max = (blk == 1) ? 0 : ((blk == 3) ? 3 : 15);
			n = 0;
			while (n < 58) begin
				len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
				                                   : $urandom_range(1, 16);
				gmax = $urandom_range(0, 1) ? 4'd15 : 4'd0;
				for (int i = 0; i < len; i++)
					queue_word(rand_station(), rand_station(), rand_station(),
					           rand_station(), i == len - 1,
					           i == 0 && $urandom_range(0, 19) == 0, gmax);
				n += len;
			end
			wait_idle();
		end

		// let any stray word surface after the last burst
		repeat (20) @(negedge clk);
		if (vis_expected.size() != 0) begin
			$error("%0d visibilities never arrived", vis_expected.size());
			err_cnt++;
		end
		$display("%0d sample words over %0d tiles, directed extremes then random lengths",
		         words_sent, tiles_queued);
		$display("%0d visibilities checked, %0d errors", vis_checked, err_cnt);
		if (err_cnt == 0)
			$display("dual_pol_correlator_tile_2x2_unit: match");
		else
			$display("dual_pol_correlator_tile_2x2_unit: mismatch");
		$finish;
	end

	// overall time limit
	initial begin : watchdog
		#(10_000_000);
		$display("dual_pol_correlator_tile_2x2_unit: mismatch");
		$finish;
	end

endmodule
